FILE: rtl/keyboard_joint_jog_controller_unit_defines.svh
// ----------------------------------------------------------------------------
// Keyboard joint jog controller - assertion macros
// Shared concurrent assertion forms for the jog controller RTL.
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_JOINT_JOG_CONTROLLER_UNIT_DEFINES_SVH
`define KEYBOARD_JOINT_JOG_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define KJJ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kjj assertion failed");

// next-cycle implication, disabled in reset
`define KJJ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kjj assertion failed");

`endif

FILE: rtl/kjj_pkg.sv
// ----------------------------------------------------------------------------
// kjj_pkg
// Types, constants and key map for the keyboard joint jog controller.
// ----------------------------------------------------------------------------
package kjj_pkg;

   localparam int SCAN_WIDTH      = 8;
   localparam int POS_WIDTH       = 8;
   localparam int COUNT_WIDTH     = 8;
   localparam int NUM_KEYS        = 10;
   localparam int MAX_JOINTS      = 5;
   localparam int NUM_JOINTS_DEFAULT = 5;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [SCAN_WIDTH-1:0]  BREAK_PREFIX = 8'hF0;
   localparam logic [POS_WIDTH-1:0]   HOME_POS     = 8'd90;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX    = 8'hFF;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ACCEL_THRESHOLD = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SLOW_STEP       = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FAST_STEP       = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_POSITION_MAX    = 8'd3;

   localparam logic [7:0] RESET_ACCEL_THRESHOLD = 8'd20;
   localparam logic [7:0] RESET_SLOW_STEP       = 8'd1;
   localparam logic [7:0] RESET_FAST_STEP       = 8'd10;
   localparam logic [7:0] RESET_POSITION_MAX    = 8'd180;

   localparam logic [SCAN_WIDTH-1:0] KEY_CODES [NUM_KEYS] = '{
      8'h1C, 8'h1A, 8'h1B, 8'h22, 8'h23, 8'h21, 8'h2B, 8'h2A, 8'h34, 8'h32
   };

   typedef struct packed {
      logic [7:0] accel_threshold;
      logic [7:0] slow_step;
      logic [7:0] fast_step;
      logic [7:0] position_max;
   } cfg_type;

   typedef struct packed {
      logic                  fire;
      logic                  byte_valid;
      logic [SCAN_WIDTH-1:0] scan_byte;
   } tick_type;

endpackage

FILE: rtl/kjj_if.sv
// ----------------------------------------------------------------------------
// kjj channel interfaces
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface kjj_req_if;
   logic                            valid;
   logic                            ready;
   logic                            byte_valid;
   logic [kjj_pkg::SCAN_WIDTH-1:0]  scan_byte;

   modport source (output valid, output byte_valid, output scan_byte, input ready);
   modport sink   (input valid, input byte_valid, input scan_byte, output ready);
endinterface

interface kjj_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [kjj_pkg::NUM_KEYS-1:0]   key_mask;
   logic [kjj_pkg::POS_WIDTH-1:0]  joint0_position;
   logic [kjj_pkg::POS_WIDTH-1:0]  joint1_position;
   logic [kjj_pkg::POS_WIDTH-1:0]  joint2_position;
   logic [kjj_pkg::POS_WIDTH-1:0]  joint3_position;
   logic [kjj_pkg::POS_WIDTH-1:0]  joint4_position;

   modport source (output valid, output key_mask, output joint0_position,
                   output joint1_position, output joint2_position,
                   output joint3_position, output joint4_position, input ready);
   modport sink   (input valid, input key_mask, input joint0_position,
                   input joint1_position, input joint2_position,
                   input joint3_position, input joint4_position, output ready);
endinterface

interface kjj_csr_if;
   logic                                valid;
   logic                                ready;
   logic [kjj_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [kjj_pkg::CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/kjj_key_tracker.sv
// ----------------------------------------------------------------------------
// kjj_key_tracker
// Break prefix flag and held-key flags, updated from one scan byte per tick.
// ----------------------------------------------------------------------------
module kjj_key_tracker (
   input  logic                           clock,
   input  logic                           reset,
   input  kjj_pkg::tick_type              tick,
   output logic [kjj_pkg::NUM_KEYS-1:0]   key_held_next
);
   import kjj_pkg::*;

   logic                release_pending_ff;
   logic                release_pending_in;
   logic [NUM_KEYS-1:0] key_held_ff;
   logic [NUM_KEYS-1:0] key_held_in;

   always_comb begin
      release_pending_in = release_pending_ff;
      key_held_in        = key_held_ff;
      if (tick.byte_valid) begin
         if (tick.scan_byte == BREAK_PREFIX) begin
            release_pending_in = 1'b1;
         end else begin
            for (int k = 0; k < NUM_KEYS; k++) begin
               if (tick.scan_byte == KEY_CODES[k]) begin
                  key_held_in[k] = !release_pending_ff;
               end
            end
            release_pending_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         release_pending_ff <= 1'b0;
         key_held_ff        <= '0;
      end else if (tick.fire) begin
         release_pending_ff <= release_pending_in;
         key_held_ff        <= key_held_in;
      end
   end

   assign key_held_next = key_held_in;

endmodule

FILE: rtl/kjj_joint_lane.sv
// ----------------------------------------------------------------------------
// kjj_joint_lane
// One joint: raise/lower hold counters, step select and clamped position.
// ----------------------------------------------------------------------------
module kjj_joint_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  logic                          up_held,
   input  logic                          dn_held,
   input  kjj_pkg::cfg_type              cfg,
   output logic [kjj_pkg::POS_WIDTH-1:0] position_next
);
   import kjj_pkg::*;

   logic [COUNT_WIDTH-1:0] up_count_ff;
   logic [COUNT_WIDTH-1:0] up_count_in;
   logic [COUNT_WIDTH-1:0] dn_count_ff;
   logic [COUNT_WIDTH-1:0] dn_count_in;
   logic [POS_WIDTH-1:0]   position_ff;
   logic [POS_WIDTH-1:0]   position_in;
   logic [POS_WIDTH-1:0]   up_step;
   logic [POS_WIDTH-1:0]   dn_step;
   logic [POS_WIDTH:0]     raised;
   logic [POS_WIDTH-1:0]   after_raise;

   always_comb begin
      up_count_in = '0;
      if (up_held) begin
         up_count_in = (up_count_ff == COUNT_MAX) ? up_count_ff : up_count_ff + 1'b1;
      end
      dn_count_in = '0;
      if (dn_held) begin
         dn_count_in = (dn_count_ff == COUNT_MAX) ? dn_count_ff : dn_count_ff + 1'b1;
      end
      up_step = (up_count_in > cfg.accel_threshold) ? cfg.fast_step : cfg.slow_step;
      dn_step = (dn_count_in > cfg.accel_threshold) ? cfg.fast_step : cfg.slow_step;

      raised      = {1'b0, position_ff} + {1'b0, up_step};
      after_raise = position_ff;
      if (up_held) begin
         after_raise = (raised > {1'b0, cfg.position_max}) ?
                       cfg.position_max : raised[POS_WIDTH-1:0];
      end

      position_in = after_raise;
      if (dn_held) begin
         position_in = (dn_step > after_raise) ? '0 : after_raise - dn_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_count_ff <= '0;
         dn_count_ff <= '0;
         position_ff <= HOME_POS;
      end else if (fire) begin
         up_count_ff <= up_count_in;
         dn_count_ff <= dn_count_in;
         position_ff <= position_in;
      end
   end

   assign position_next = position_in;

endmodule

FILE: rtl/keyboard_joint_jog_controller_unit.sv
// ----------------------------------------------------------------------------
// keyboard_joint_jog_controller_unit
// Keyboard driven jog of up to five joints with hold-time acceleration.
// ----------------------------------------------------------------------------
// One response per request, one request per cycle sustained while the response
// channel does not stall. A request is captured in an input register; when the
// output register is free, the key flags and every joint lane update in a single
// pass and the response is loaded into the output register.
// The sustained rate is set by the key/lane state update loop, which closes in a single pass.
// Registers may be written only while no request is in flight.
// ----------------------------------------------------------------------------
`include "keyboard_joint_jog_controller_unit_defines.svh"

module keyboard_joint_jog_controller_unit #(
   parameter int NUM_JOINTS = kjj_pkg::NUM_JOINTS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   kjj_req_if.sink   req_chan,
   kjj_rsp_if.source rsp_chan,
   kjj_csr_if.sink   csr_chan
);
   import kjj_pkg::*;

   cfg_type               cfg_ff;
   cfg_type               cfg_in;

   logic                  s1_valid_ff;
   logic                  s1_byte_valid_ff;
   logic [SCAN_WIDTH-1:0] s1_scan_byte_ff;

   logic                  rsp_valid_ff;
   logic [NUM_KEYS-1:0]   rsp_key_mask_ff;
   logic [POS_WIDTH-1:0]  rsp_pos_ff [MAX_JOINTS];

   logic                  out_free;
   logic                  advance;
   logic                  req_take;
   tick_type              tick;
   logic [NUM_KEYS-1:0]   key_held_next;
   logic [POS_WIDTH-1:0]  pos_next [MAX_JOINTS];

   // register writes
   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_ACCEL_THRESHOLD: cfg_in.accel_threshold = csr_chan.data[7:0];
            REG_SLOW_STEP:       cfg_in.slow_step       = csr_chan.data[7:0];
            REG_FAST_STEP:       cfg_in.fast_step       = csr_chan.data[7:0];
            REG_POSITION_MAX:    cfg_in.position_max    = csr_chan.data[7:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accel_threshold <= RESET_ACCEL_THRESHOLD;
         cfg_ff.slow_step       <= RESET_SLOW_STEP;
         cfg_ff.fast_step       <= RESET_FAST_STEP;
         cfg_ff.position_max    <= RESET_POSITION_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pipeline control
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_valid_ff <= req_chan.byte_valid;
         s1_scan_byte_ff  <= req_chan.scan_byte;
      end
   end

   assign tick.fire       = advance;
   assign tick.byte_valid = s1_byte_valid_ff;
   assign tick.scan_byte  = s1_scan_byte_ff;

   kjj_key_tracker u_keys (
      .clock         (clock),
      .reset         (reset),
      .tick          (tick),
      .key_held_next (key_held_next)
   );

   for (genvar j = 0; j < MAX_JOINTS; j++) begin : g_lane
      if (j < NUM_JOINTS) begin : g_used
         kjj_joint_lane u_lane (
            .clock         (clock),
            .reset         (reset),
            .fire          (advance),
            .up_held       (key_held_next[2*j]),
            .dn_held       (key_held_next[2*j+1]),
            .cfg           (cfg_ff),
            .position_next (pos_next[j])
         );
      end else begin : g_unused
         assign pos_next[j] = '0;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_key_mask_ff <= key_held_next;
         for (int j = 0; j < MAX_JOINTS; j++) begin
            rsp_pos_ff[j] <= pos_next[j];
         end
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.key_mask        = rsp_key_mask_ff;
   assign rsp_chan.joint0_position = rsp_pos_ff[0];
   assign rsp_chan.joint1_position = rsp_pos_ff[1];
   assign rsp_chan.joint2_position = rsp_pos_ff[2];
   assign rsp_chan.joint3_position = rsp_pos_ff[3];
   assign rsp_chan.joint4_position = rsp_pos_ff[4];

   // checks
   `KJJ_ASSERT_NEXT(a_advance_loads_rsp, clock, reset, advance, rsp_valid_ff)
   `KJJ_ASSERT_NEXT(a_stalled_s1_holds, clock, reset, s1_valid_ff && !out_free, s1_valid_ff)
   `KJJ_ASSERT_SAME(a_take_only_when_free, clock, reset, req_take && s1_valid_ff, advance)

endmodule

FILE: test/tb_keyboard_joint_jog_controller_unit.sv
// ----------------------------------------------------------------------------
// tb_keyboard_joint_jog_controller_unit
// Drives scan byte ticks into the jog controller and checks every response
// (key mask and joint positions) against a cycle-free model of the key flags,
// hold counters and clamped joint arithmetic kept inside this bench.
// ----------------------------------------------------------------------------
module tb_keyboard_joint_jog_controller_unit;
   import kjj_pkg::*;

   localparam int JOINTS      = NUM_JOINTS_DEFAULT;
   localparam int QUIET_LIMIT = 500;
   localparam int TAIL_CYCLES = 6;
   localparam int PHASE_TICKS = 100;
   localparam int NUM_PHASES  = 6;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FIRST_UNUSED = 8'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LAST_UNUSED  = 8'hFF;

   typedef struct packed {
      logic [NUM_KEYS-1:0]                  key_mask;
      logic [MAX_JOINTS-1:0][POS_WIDTH-1:0] joint_pos;
   } jog_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   kjj_req_if req_bus ();
   kjj_rsp_if rsp_bus ();
   kjj_csr_if csr_bus ();

   keyboard_joint_jog_controller_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #5 clock = ~clock;

   // model state
   cfg_type        jog_cfg;
   logic           release_armed;
   logic           key_down   [NUM_KEYS];
   logic [7:0]     hold_ticks [NUM_KEYS];
   logic [7:0]     jog_pos    [MAX_JOINTS];
   jog_result_type expected_jogs [$];

   int  mismatches   = 0;
   int  n_sent       = 0;
   int  n_checked    = 0;
   int  n_writes     = 0;
   int  quiet_cycles = 0;
   int  stall_left   = 0;
   bit  req_idle_on  = 1'b1;
   bit  rsp_stall_on = 1'b1;

   logic [CSR_INDEX_WIDTH-1:0] reg_list [4] = '{
      REG_ACCEL_THRESHOLD, REG_SLOW_STEP, REG_FAST_STEP, REG_POSITION_MAX
   };

   function automatic logic [7:0] hold_step(input int k);
      if (hold_ticks[k] != COUNT_MAX) hold_ticks[k] = hold_ticks[k] + 8'd1;
      return (hold_ticks[k] > jog_cfg.accel_threshold) ? jog_cfg.fast_step : jog_cfg.slow_step;
   endfunction

   function automatic jog_result_type advance_jog(input logic bv, input logic [7:0] sb);
      jog_result_type res;
      logic [8:0]     sum;
      logic [7:0]     stp;
      int             up;
      int             dn;
      if (bv) begin
         if (sb == BREAK_PREFIX) begin
            release_armed = 1'b1;
         end else begin
            for (int k = 0; k < NUM_KEYS; k++) begin
               if (sb == KEY_CODES[k]) key_down[k] = !release_armed;
            end
            release_armed = 1'b0;
         end
      end
      res = '0;
      for (int k = 0; k < NUM_KEYS; k++) res.key_mask[k] = key_down[k];
      for (int j = 0; j < JOINTS; j++) begin
         up = 2 * j;
         dn = up + 1;
         if (key_down[up]) begin
            stp = hold_step(up);
            sum = {1'b0, jog_pos[j]} + {1'b0, stp};
            jog_pos[j] = (sum > {1'b0, jog_cfg.position_max}) ? jog_cfg.position_max : sum[7:0];
         end else begin
            hold_ticks[up] = 8'd0;
         end
         if (key_down[dn]) begin
            stp = hold_step(dn);
            jog_pos[j] = (stp > jog_pos[j]) ? 8'd0 : jog_pos[j] - stp;
         end else begin
            hold_ticks[dn] = 8'd0;
         end
         res.joint_pos[j] = jog_pos[j];
      end
      return res;
   endfunction

   // request capture, response check and register shadow, all on one edge
   always @(posedge clock) begin
      jog_result_type got;
      jog_result_type want;
      logic           busy;
      busy = 1'b0;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            expected_jogs.push_back(advance_jog(req_bus.byte_valid, req_bus.scan_byte));
            busy = 1'b1;
         end
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               REG_ACCEL_THRESHOLD: jog_cfg.accel_threshold = csr_bus.data[7:0];
               REG_SLOW_STEP:       jog_cfg.slow_step       = csr_bus.data[7:0];
               REG_FAST_STEP:       jog_cfg.fast_step       = csr_bus.data[7:0];
               REG_POSITION_MAX:    jog_cfg.position_max    = csr_bus.data[7:0];
               default: ;
            endcase
            busy = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            busy = 1'b1;
            got.key_mask  = rsp_bus.key_mask;
            got.joint_pos = {rsp_bus.joint4_position, rsp_bus.joint3_position,
                             rsp_bus.joint2_position, rsp_bus.joint1_position,
                             rsp_bus.joint0_position};
            if (expected_jogs.size() == 0) begin
               $display("%0t: unexpected response, expected none actual %h", $time, got);
               mismatches++;
            end else begin
               want = expected_jogs.pop_front();
               n_checked++;
               if (got.key_mask !== want.key_mask) begin
                  $display("%0t: key_mask expected %h actual %h", $time,
                           want.key_mask, got.key_mask);
                  mismatches++;
               end
               for (int j = 0; j < MAX_JOINTS; j++) begin
                  if (got.joint_pos[j] !== want.joint_pos[j]) begin
                     $display("%0t: joint%0d_position expected %0d actual %0d", $time, j,
                              want.joint_pos[j], got.joint_pos[j]);
                     mismatches++;
                  end
               end
            end
         end
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
   end

   // response back-pressure in bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else if (rsp_stall_on && $urandom_range(0, 4) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= $urandom_range(0, 7);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("keyboard_joint_jog_controller_unit: mismatch");
      $finish;
   end

   // leaves valid high after acceptance so back-to-back requests never toggle it
   task automatic send_tick(input logic bv, input logic [7:0] sb);
      if (req_idle_on && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.byte_valid <= bv;
      req_bus.scan_byte  <= sb;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      n_sent++;
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (expected_jogs.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [CSR_DATA_WIDTH-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
      n_writes++;
   endtask

   task automatic test_idle_ticks();
      send_tick(1'b0, 8'h00);
      send_tick(1'b0, 8'hFF);
   endtask

   task automatic test_press_and_release();
      send_tick(1'b1, KEY_CODES[0]);
      send_tick(1'b0, 8'h00);
      send_tick(1'b1, BREAK_PREFIX);
      send_tick(1'b1, KEY_CODES[0]);
      send_tick(1'b1, KEY_CODES[1]);
      send_tick(1'b1, BREAK_PREFIX);
      send_tick(1'b1, KEY_CODES[1]);
   endtask

   // double prefix stays armed; an unmapped byte disarms it
   task automatic test_prefix_handling();
      send_tick(1'b1, BREAK_PREFIX);
      send_tick(1'b1, BREAK_PREFIX);
      send_tick(1'b1, KEY_CODES[3]);
      send_tick(1'b1, KEY_CODES[3]);
      send_tick(1'b1, BREAK_PREFIX);
      send_tick(1'b1, 8'h77);
      send_tick(1'b1, KEY_CODES[3]);
   endtask

   task automatic test_register_extremes();
      for (int k = 4; k < NUM_KEYS; k++) send_tick(1'b1, KEY_CODES[k]);
      settle();
      write_register(REG_ACCEL_THRESHOLD, 32'hDEAD_BE00);
      write_register(REG_SLOW_STEP,       32'h0000_0100);
      write_register(REG_FAST_STEP,       32'h1234_56FF);
      write_register(REG_POSITION_MAX,    32'hFFFF_FF00);
      write_register(REG_FIRST_UNUSED,    32'h0000_00FF);
      write_register(REG_LAST_UNUSED,     32'hFFFF_FF55);
      send_tick(1'b0, 8'h5A);
      send_tick(1'b0, 8'hA5);
      settle();
      write_register(REG_ACCEL_THRESHOLD, 32'h0000_00FF);
      write_register(REG_SLOW_STEP,       32'hFFFF_FFFF);
      write_register(REG_FAST_STEP,       32'h8000_0000);
      write_register(REG_POSITION_MAX,    32'h7FFF_FFFF);
      send_tick(1'b0, 8'h00);
      send_tick(1'b0, 8'hFF);
   endtask

   task automatic random_sequence();
      int         pick;
      int         k;
      logic [7:0] rb;
      pick = $urandom_range(0, 99);
      k    = $urandom_range(0, NUM_KEYS - 1);
      rb   = 8'($urandom);
      if (pick < 45) begin
         send_tick(1'b1, KEY_CODES[k]);
         repeat ($urandom_range(0, 40)) send_tick(1'b0, 8'($urandom));
         send_tick(1'b1, BREAK_PREFIX);
         send_tick(1'b1, KEY_CODES[k]);
      end else if (pick < 60) begin
         send_tick(1'b1, KEY_CODES[k]);
      end else if (pick < 70) begin
         if ($urandom_range(0, 2) == 0) send_tick(1'b1, BREAK_PREFIX);
         send_tick(1'b1, BREAK_PREFIX);
         send_tick(1'b1, KEY_CODES[k]);
      end else if (pick < 78) begin
         send_tick(1'b1, BREAK_PREFIX);
         send_tick(1'b1, (rb == BREAK_PREFIX) ? 8'h00 : rb);
      end else if (pick < 90) begin
         send_tick(1'b1, rb);
      end else begin
         repeat ($urandom_range(1, 5)) send_tick(1'($urandom), 8'($urandom));
      end
   endtask

   task automatic test_random_jogging();
      int         target;
      int         pick;
      logic [7:0] low;
      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         req_idle_on  = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
         rsp_stall_on = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
         for (int r = 0; r < 4; r++) begin
            pick = $urandom_range(0, 3);
            low  = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
            write_register(reg_list[r], {24'($urandom), low});
         end
         if ($urandom_range(0, 2) == 0)
            write_register(8'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)), $urandom);
         target = n_sent + PHASE_TICKS;
         if (p == 2) begin
            // hold one key long enough for its counter to saturate
            write_register(REG_ACCEL_THRESHOLD, 32'h0000_00FF);
            send_tick(1'b1, KEY_CODES[8]);
            repeat (262) send_tick(1'b0, 8'($urandom));
            send_tick(1'b1, BREAK_PREFIX);
            send_tick(1'b1, KEY_CODES[8]);
         end
         while (n_sent < target) random_sequence();
      end
   endtask

   initial begin
      req_bus.valid      = 1'b0;
      req_bus.byte_valid = 1'b0;
      req_bus.scan_byte  = '0;
      rsp_bus.ready      = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = '0;
      csr_bus.data       = '0;
      jog_cfg = '{RESET_ACCEL_THRESHOLD, RESET_SLOW_STEP, RESET_FAST_STEP, RESET_POSITION_MAX};
      release_armed = 1'b0;
      for (int k = 0; k < NUM_KEYS; k++) begin
         key_down[k]   = 1'b0;
         hold_ticks[k] = 8'd0;
      end
      for (int j = 0; j < MAX_JOINTS; j++) jog_pos[j] = HOME_POS;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_idle_ticks();
      test_press_and_release();
      test_prefix_handling();
      test_register_extremes();
      test_random_jogging();

      req_bus.valid <= 1'b0;
      while (expected_jogs.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d tick requests, %0d responses checked, %0d register writes",
               n_sent, n_checked, n_writes);
      $display("directed key/prefix cases, register extremes, %0d random settings phases",
               NUM_PHASES);
      if (mismatches == 0 && expected_jogs.size() == 0) begin
         $display("keyboard_joint_jog_controller_unit: match");
      end else begin
         $display("keyboard_joint_jog_controller_unit: mismatch");
      end
      $finish;
   end

endmodule
